// File: rtl/josephus_survivor_unit_macros.svh
// Assertion macros used by the Josephus survivor unit datapath.
`ifndef JOSEPHUS_SURVIVOR_UNIT_MACROS_SVH
`define JOSEPHUS_SURVIVOR_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on clk, masked during rst.
`define JSU_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");
// Next-cycle implication, checked on clk, masked during rst.
`define JSU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");
`else
`define JSU_ASSERT_SAME(label, ante, cons)
`define JSU_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/jsu_pkg.sv
// Shared constants and control/status types of the Josephus survivor unit.
`timescale 1ns / 1ps
package jsu_pkg;

  localparam int MAX_PEOPLE_DEF = 64;
  localparam int MAX_STEP_DEF   = 255;

  localparam int RING_W = 7;
  localparam int START_W = 7;
  localparam int STEP_W = 8;
  localparam int SURV_W = 7;
  localparam int IN_DATA_W = 24;
  localparam int OUT_DATA_W = 8;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_BAD_START = 1'b1;

  typedef struct packed {
    logic load;
    logic clear;
    logic check;
    logic finish;
  } jsu_cmd_t;

  typedef struct packed {
    logic special;
    logic clear_last;
    logic walk_done;
    logic out_free;
  } jsu_stat_t;

endpackage

// File: rtl/jsu_ctrl.sv
// Sequencer of the Josephus survivor unit: accept, clear, probe/check walk, finish.
`timescale 1ns / 1ps
module jsu_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  jsu_pkg::jsu_stat_t stat,
  output jsu_pkg::jsu_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_PROBE = 3'd2;
  localparam logic [2:0] ST_CHECK = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready   = (state == ST_IDLE);
  assign cmd.load   = in_valid && in_ready;
  assign cmd.clear  = (state == ST_CLEAR);
  assign cmd.check  = (state == ST_CHECK);
  assign cmd.finish = (state == ST_FIN) && stat.out_free;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = stat.special ? ST_FIN : ST_CLEAR;
      end
      ST_CLEAR: begin
        if (stat.clear_last) state_next = ST_PROBE;
      end
      ST_PROBE: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = stat.walk_done ? ST_FIN : ST_PROBE;
      end
      ST_FIN: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/jsu_datapath.sv
// Datapath of the Josephus survivor unit: ring registers, alive memory, result register.
`timescale 1ns / 1ps
`include "josephus_survivor_unit_macros.svh"
module jsu_datapath #(
  parameter int MAX_PEOPLE = jsu_pkg::MAX_PEOPLE_DEF,
  parameter int MAX_STEP   = jsu_pkg::MAX_STEP_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [jsu_pkg::RING_W-1:0]  ring_size,
  input  logic [jsu_pkg::START_W-1:0] start_position,
  input  logic [jsu_pkg::STEP_W-1:0]  step_count,
  input  jsu_pkg::jsu_cmd_t           cmd,
  output jsu_pkg::jsu_stat_t          stat,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [jsu_pkg::SURV_W-1:0]  survivor,
  output logic                        status
);

  localparam int PW = $clog2(MAX_PEOPLE);
  localparam int NW = $clog2(MAX_PEOPLE + 1);
  localparam int CW = $clog2(MAX_STEP + 1);

  logic [NW-1:0] n_sat;
  logic [CW-1:0] k_sat;
  logic          bad_start;

  logic [NW-1:0] n_reg;
  logic [CW-1:0] k_reg;
  logic [PW-1:0] pos;
  logic [PW-1:0] cand;
  logic [PW-1:0] last_pos;
  logic [CW-1:0] count;
  logic [CW-1:0] count_inc;
  logic [NW-1:0] left;
  logic          after_kill;
  logic [PW-1:0] clr_addr;

  logic          alive_mem [MAX_PEOPLE];
  logic          rd_alive;
  logic          mem_we;
  logic [PW-1:0] mem_waddr;
  logic          mem_wdata;
  logic          kill;

  logic [jsu_pkg::SURV_W-1:0] res_surv;
  logic                       res_stat;

  // Saturate the request fields to the ring limits.
  always_comb begin
    if (32'(ring_size) > MAX_PEOPLE) n_sat = NW'(MAX_PEOPLE);
    else n_sat = NW'(ring_size);
    if (step_count == '0) k_sat = CW'(1);
    else if (32'(step_count) > MAX_STEP) k_sat = CW'(MAX_STEP);
    else k_sat = CW'(step_count);
  end

  assign bad_start    = (start_position == '0) || (32'(start_position) > 32'(n_sat));
  assign stat.special = bad_start || (n_sat == NW'(1)) || (k_sat == CW'(1));

  assign last_pos  = PW'(n_reg - NW'(1));
  assign cand      = (pos == last_pos) ? '0 : PW'(pos + PW'(1));
  assign count_inc = CW'(count + CW'(1));
  assign kill      = cmd.check && rd_alive && !after_kill && (count_inc == k_reg);

  assign stat.clear_last = (clr_addr == last_pos);
  assign stat.walk_done  = after_kill && rd_alive && (left == NW'(1));
  assign stat.out_free   = !out_valid || out_ready;

  assign mem_we    = cmd.clear || kill;
  assign mem_waddr = cmd.clear ? clr_addr : cand;
  assign mem_wdata = cmd.clear;

  always_ff @(posedge clk) begin
    if (mem_we) alive_mem[mem_waddr] <= mem_wdata;
    rd_alive <= alive_mem[cand];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_reg      <= n_sat;
      k_reg      <= k_sat;
      pos        <= PW'(32'(start_position) - 1);
      count      <= CW'(1);
      left       <= n_sat;
      after_kill <= 1'b0;
      clr_addr   <= '0;
      if (bad_start) begin
        res_surv <= '0;
        res_stat <= jsu_pkg::STATUS_BAD_START;
      end else if (n_sat == NW'(1)) begin
        res_surv <= jsu_pkg::SURV_W'(1);
        res_stat <= jsu_pkg::STATUS_OK;
      end else begin
        res_surv <= (start_position > jsu_pkg::START_W'(1))
                    ? jsu_pkg::SURV_W'(start_position - jsu_pkg::START_W'(1))
                    : jsu_pkg::SURV_W'(n_sat);
        res_stat <= jsu_pkg::STATUS_OK;
      end
    end else begin
      if (cmd.clear) clr_addr <= PW'(clr_addr + PW'(1));
      if (cmd.check && rd_alive) begin
        pos <= cand;
        if (after_kill) begin
          after_kill <= 1'b0;
          if (left == NW'(1)) begin
            res_surv <= jsu_pkg::SURV_W'(32'(cand) + 1);
            res_stat <= jsu_pkg::STATUS_OK;
          end
        end else if (count_inc == k_reg) begin
          left       <= NW'(left - NW'(1));
          count      <= CW'(1);
          after_kill <= 1'b1;
        end else begin
          count <= count_inc;
        end
      end else if (cmd.check) begin
        pos <= cand;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      survivor <= res_surv;
      status   <= res_stat;
    end
  end

  `JSU_ASSERT_SAME(a_pos_in_ring, cmd.check, NW'(pos) < n_reg)
  `JSU_ASSERT_SAME(a_count_below_step, cmd.check, (left != '0) && (count < k_reg))
  `JSU_ASSERT_SAME(a_no_kill_of_last, kill, left > NW'(1))

endmodule

// File: rtl/josephus_survivor_unit.sv
// Top level of the Josephus survivor unit: sequencer plus ring datapath.
//
//  channel   | dir | tdata fields (low bit up)                       | tuser
//  s_axis    | in  | ring_size[6:0] start_position[13:7] step_count[21:14] | none
//  m_axis    | out | survivor[6:0]                                   | status[0]
//
// Order: the request is accepted, every alive mark is set, then the walk
// steps over each ring position (live or dead) in a probe state and a check
// state, as the single-port alive memory has a registered read; the result
// goes to the output register last. Bad starts, a ring of one and a step of
// one skip the clear and the walk and go straight to the finish.
// Reset: rst is synchronous, active high; it idles the sequencer and empties
// the output register. The alive memory needs no reset; each walk clears it first.
// Stalls: a result waits in the output register while the next request is
// taken; a finished walk holds until that register is free.
`timescale 1ns / 1ps
module josephus_survivor_unit #(
  parameter int MAX_PEOPLE = jsu_pkg::MAX_PEOPLE_DEF,
  parameter int MAX_STEP   = jsu_pkg::MAX_STEP_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // ring_size[6:0], start_position[13:7], step_count[21:14], zero [23:22]
  input  logic [jsu_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // survivor[6:0], zero [7]
  output logic [jsu_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // status[0]
  output logic [0:0]                      m_axis_tuser
);

  jsu_pkg::jsu_cmd_t  cmd;
  jsu_pkg::jsu_stat_t stat;

  logic [jsu_pkg::SURV_W-1:0] survivor;
  logic                       status;

  // Sequence each request: accept, clear marks, walk, hand over the result.
  jsu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold the ring state, the alive memory and the result register.
  jsu_datapath #(
    .MAX_PEOPLE (MAX_PEOPLE),
    .MAX_STEP   (MAX_STEP)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .ring_size      (s_axis_tdata[6:0]),
    .start_position (s_axis_tdata[13:7]),
    .step_count     (s_axis_tdata[21:14]),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .survivor       (survivor),
    .status         (status)
  );

  // Pack the result; pad tdata to a whole byte.
  assign m_axis_tdata = {{(jsu_pkg::OUT_DATA_W - jsu_pkg::SURV_W){1'b0}}, survivor};
  assign m_axis_tuser = status;

endmodule

// File: verif/tb_josephus_survivor_unit.sv
// Self-checking testbench for the Josephus survivor unit stream interface.
`timescale 1ns / 1ps
module tb_josephus_survivor_unit;

  localparam int MAX_PEOPLE = jsu_pkg::MAX_PEOPLE_DEF;
  localparam int MAX_STEP   = jsu_pkg::MAX_STEP_DEF;
  localparam int CLK_PERIOD = 12;
  // The worst walk (64 seats, step 255) sets the bound; allow many times the full run.
  localparam int TIMEOUT_CYCLES = 2_500_000;
  // Quiet time after the last result, well above the latency of a shortcut request.
  localparam int DRAIN_CYCLES = 300;

  // One request as the block sees it, first field in the low bits.
  typedef struct packed {
    logic [jsu_pkg::STEP_W-1:0]  step_count;
    logic [jsu_pkg::START_W-1:0] start_position;
    logic [jsu_pkg::RING_W-1:0]  ring_size;
  } ring_request_t;

  typedef struct {
    ring_request_t req;
    bit            wait_idle;  // hold this request until every result is back
  } queued_request_t;

  typedef struct packed {
    logic [jsu_pkg::SURV_W-1:0] survivor;
    logic                       status;
  } survivor_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  // ring_size[6:0], start_position[13:7], step_count[21:14], zero [23:22]
  logic [jsu_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  // survivor[6:0], zero [7]
  logic [jsu_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  // status[0]
  logic [0:0]                     m_axis_tuser;

  queued_request_t  request_queue[$];
  survivor_result_t survivor_queue[$];

  bit               ring_alive[MAX_PEOPLE];
  ring_request_t    request_in_flight;
  queued_request_t  next_request;
  survivor_result_t oldest_survivor;
  int               requests_taken = 0;
  int               results_taken  = 0;
  int               failures       = 0;
  int               send_gap       = 0;
  int               ready_hold     = 0;

  josephus_survivor_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Advance to the next live seat, wrapping at the ring end; give up after one full lap.
  function automatic int next_live_seat(int pos, int ring_n);
    int tries;
    tries = 0;
    do begin
      pos++;
      if (pos >= ring_n) pos = 0;
      tries++;
    end while (!ring_alive[pos] && tries <= ring_n);
    return pos;
  endfunction

  // Work out the survivor for one request, shortcuts first, then a full walk of the ring.
  function automatic survivor_result_t predict_survivor(ring_request_t req);
    survivor_result_t res;
    int ring_n;
    int step_k;
    int pos;
    int count;
    int left;
    res.survivor = '0;
    res.status   = jsu_pkg::STATUS_OK;
    // Saturate the ring size and the step; a zero step behaves as a step of one.
    ring_n = (req.ring_size > MAX_PEOPLE) ? MAX_PEOPLE : int'(req.ring_size);
    step_k = (req.step_count == 0) ? 1 : int'(req.step_count);
    if (step_k > MAX_STEP) step_k = MAX_STEP;
    if (req.start_position == 0 || req.start_position > ring_n) begin
      res.status = jsu_pkg::STATUS_BAD_START;
    end else if (ring_n == 1) begin
      res.survivor = jsu_pkg::SURV_W'(1);
    end else if (step_k == 1) begin
      res.survivor = jsu_pkg::SURV_W'((req.start_position > 1)
                                      ? int'(req.start_position) - 1 : ring_n);
    end else begin
      for (int i = 0; i < MAX_PEOPLE; i++) ring_alive[i] = 1'b1;
      pos   = req.start_position - 1;
      count = 1;
      left  = ring_n;
      while (left > 1) begin
        pos = next_live_seat(pos, ring_n);
        count++;
        if (count == step_k) begin
          // Drop the counted seat and restart the count on the next live one.
          ring_alive[pos] = 1'b0;
          left--;
          count = 1;
          pos = next_live_seat(pos, ring_n);
        end
      end
      for (int i = ring_n - 1; i >= 0; i--) begin
        if (ring_alive[i]) res.survivor = jsu_pkg::SURV_W'(i + 1);
      end
    end
    return res;
  endfunction

  task automatic add_request(int ring_n, int start_m, int step_k, bit wait_idle);
    queued_request_t item;
    item.req.ring_size      = jsu_pkg::RING_W'(ring_n);
    item.req.start_position = jsu_pkg::START_W'(start_m);
    item.req.step_count     = jsu_pkg::STEP_W'(step_k);
    item.wait_idle          = wait_idle;
    request_queue.push_back(item);
  endtask

  // Request driver: hold a request until taken, then idle for a random gap.
  always @(posedge clk) begin : request_driver
    bit next_valid;
    int pick;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      send_gap = 0;
    end else begin
      next_valid = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        // Predict at acceptance so the expectation order matches the request order.
        survivor_queue.push_back(predict_survivor(request_in_flight));
        requests_taken++;
        next_valid = 1'b0;
        pick = $urandom_range(0, 99);
        if (requests_taken >= 40 && requests_taken < 70) send_gap = 0;
        else if (pick < 55) send_gap = 0;
        else if (pick < 90) send_gap = $urandom_range(1, 3);
        else send_gap = $urandom_range(8, 40);
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (request_queue.size() > 0 &&
                     !(request_queue[0].wait_idle && survivor_queue.size() > 0)) begin
          next_request      = request_queue.pop_front();
          request_in_flight = next_request.req;
          s_axis_tdata      <= {2'b00, next_request.req};
          next_valid        = 1'b1;
        end
      end
      s_axis_tvalid <= next_valid;
    end
  end

  // Result ready: a long hold right after reset so the block backs up, then random stalls.
  always @(posedge clk) begin : result_ready
    int pick;
    if (rst) begin
      m_axis_tready <= 1'b0;
      ready_hold = 400;
    end else if (ready_hold > 0) begin
      ready_hold--;
      m_axis_tready <= 1'b0;
    end else begin
      pick = $urandom_range(0, 999);
      if (results_taken >= 60 && results_taken < 80) begin
        m_axis_tready <= 1'b1;
      end else if (pick < 15) begin
        ready_hold = $urandom_range(20, 250);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= (pick >= 300);
      end
    end
  end

  // Result monitor: compare each taken result with the oldest prediction.
  always @(posedge clk) begin : result_monitor
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (survivor_queue.size() == 0) begin
        $error("unexpected result: survivor %0d status %0d",
               m_axis_tdata[jsu_pkg::SURV_W-1:0], m_axis_tuser[0]);
        failures++;
      end else begin
        oldest_survivor = survivor_queue.pop_front();
        results_taken++;
        if (m_axis_tdata[jsu_pkg::SURV_W-1:0] !== oldest_survivor.survivor) begin
          $error("survivor mismatch: expected %0d, actual %0d",
                 oldest_survivor.survivor, m_axis_tdata[jsu_pkg::SURV_W-1:0]);
          failures++;
        end
        if (m_axis_tuser[0] !== oldest_survivor.status) begin
          $error("status mismatch: expected %0d, actual %0d",
                 oldest_survivor.status, m_axis_tuser[0]);
          failures++;
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int pick;
    int ring_n;
    int start_m;
    int step_k;
    int ring_cap;

    // Directed part: cheap shortcuts first, so they pile up during the opening hold.
    add_request(1, 1, 1, 1'b0);       // ring of one, step of one
    add_request(1, 1, 255, 1'b0);     // ring of one, largest step
    add_request(0, 0, 0, 1'b0);       // empty ring is always a bad start
    add_request(5, 0, 3, 1'b0);       // start position zero
    add_request(5, 6, 3, 1'b0);       // start beyond the ring
    add_request(127, 127, 255, 1'b0); // ring saturates to 64, start still beyond it
    add_request(127, 64, 1, 1'b0);    // saturated ring, step of one
    add_request(10, 1, 1, 1'b0);      // step of one from seat one wraps to n
    add_request(10, 4, 0, 1'b0);      // zero step acts as a step of one
    add_request(2, 1, 2, 1'b0);
    add_request(2, 2, 255, 1'b0);
    add_request(7, 1, 3, 1'b0);
    add_request(41, 1, 3, 1'b0);
    add_request(64, 64, 2, 1'b0);
    add_request(64, 1, 128, 1'b0);
    add_request(100, 33, 5, 1'b0);    // saturated ring with a real walk
    add_request(64, 1, 255, 1'b0);    // longest walk
    add_request(3, 3, 254, 1'b0);
    add_request(16, 8, 85, 1'b0);
    add_request(21, 21, 170, 1'b0);

    // Random part: mostly small rings and steps, some bad starts, a few wide rings and long steps.
    for (int i = 0; i < 120; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        ring_n  = $urandom_range(2, 16);
        start_m = $urandom_range(1, ring_n);
        step_k  = $urandom_range(0, 15);
      end else if (pick < 80) begin
        ring_n   = $urandom_range(0, 127);
        ring_cap = (ring_n > MAX_PEOPLE) ? MAX_PEOPLE : ring_n;
        start_m  = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(ring_cap + 1, 127);
        step_k   = $urandom_range(0, 255);
      end else if (pick < 92) begin
        ring_n   = $urandom_range(17, 127);
        ring_cap = (ring_n > MAX_PEOPLE) ? MAX_PEOPLE : ring_n;
        start_m  = $urandom_range(1, ring_cap);
        step_k   = $urandom_range(0, 7);
      end else begin
        ring_n  = $urandom_range(1, 8);
        start_m = $urandom_range(1, ring_n);
        step_k  = $urandom_range(0, 255);
      end
      // Pause the sender until the directed results are all back, and again midway.
      add_request(ring_n, start_m, step_k, (i == 0) || (i == 70));
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Settle on the falling edge so all clocked updates of the step are visible.
    while (!(request_queue.size() == 0 && !s_axis_tvalid && survivor_queue.size() == 0))
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (failures == 0 && survivor_queue.size() == 0) begin
      $display("tb_josephus_survivor_unit passed");
    end else begin
      $display("tb_josephus_survivor_unit failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("tb_josephus_survivor_unit failed");
    $finish;
  end

endmodule
